[hw/rtl/prb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the packet reorder buffer.
// No dependencies; used by prb_ctrl, prb_datapath and packet_reorder_buffer.

package prb_pkg;

	localparam int unsigned WINDOW_DEFAULT = 64;

	// item kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ENQUEUE = 2'd0;
	localparam kind_t KIND_EXTRACT = 2'd1;
	localparam kind_t KIND_CLEAR   = 2'd2;

	// result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_STORED    = 3'd0;
	localparam status_t ST_OLD       = 3'd1;
	localparam status_t ST_DUPLICATE = 3'd2;
	localparam status_t ST_BEYOND    = 3'd3;
	localparam status_t ST_EXTRACTED = 3'd4;
	localparam status_t ST_NOT_READY = 3'd5;
	localparam status_t ST_CLEARED   = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch input beat
		logic calc;     // offset and range checks
		logic read;     // slot memory read
		logic exec;     // decide, write back, load result
		logic sweep;    // clear one presence entry
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_clear;
		logic sweep_done;
	} sts_t;

endpackage

[hw/rtl/prb_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the packet reorder buffer: handshakes, step commands, sweep.
// Depends on prb_pkg.

module prb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  prb_pkg::sts_t  sts,
	output prb_pkg::cmd_t  cmd
);
	import prb_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_CALC,
		S_READ,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   exec_go;

	assign out_free = !out_valid_q || out_ready;
	assign exec_go  = (state_q == S_EXEC) && out_free;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.calc    = (state_q == S_CALC);
		cmd.read    = (state_q == S_READ);
		cmd.exec    = exec_go;
		cmd.sweep   = (state_q == S_SWEEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_SWEEP: begin
					if (sts.sweep_done)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CALC;
				end
				S_CALC: state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					// a clear wipes the presence bits before the next beat
					if (out_free)
						state_q <= sts.is_clear ? S_SWEEP : S_IDLE;
				end
				default: state_q <= S_SWEEP;
			endcase
		end
	end

endmodule

[hw/rtl/prb_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the packet reorder buffer: window pointers, slot memories,
// result register. Depends on prb_pkg; driven by prb_ctrl.

module prb_datapath #(
	parameter int unsigned WINDOW = prb_pkg::WINDOW_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prb_pkg::cmd_t      cmd,
	output prb_pkg::sts_t      sts,
	input  prb_pkg::kind_t     kind,
	input  logic [31:0]        packet_id,
	input  logic [15:0]        packet_ref,
	input  logic [31:0]        request_id,
	input  logic [15:0]        header_size,
	output prb_pkg::status_t   status,
	output logic [31:0]        out_packet_id,
	output logic [15:0]        out_packet_ref,
	output logic [31:0]        out_request_id,
	output logic [15:0]        out_header_size
);
	import prb_pkg::*;

	localparam int unsigned IW = $clog2(WINDOW);
	localparam int unsigned QW = $clog2(WINDOW + 1);
	localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW - 1);
	localparam logic [IW:0]   WIN_W     = (IW + 1)'(WINDOW);

	// latched input beat
	kind_t       kind_q;
	logic [31:0] id_q;
	logic [15:0] ref_q;
	logic [31:0] req_q;
	logic [15:0] hdr_q;

	// window state
	logic [31:0]   last_id_q;
	logic [QW-1:0] qlen_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] sweep_cnt_q;

	// step results
	logic          old_q;
	logic          beyond_q;
	logic [IW-1:0] offset_q;
	logic [IW-1:0] slot_q;
	logic          present_rd_q;
	logic [63:0]   data_rd_q;

	// result register
	status_t     status_q;
	logic [31:0] res_id_q;
	logic [15:0] res_ref_q;
	logic [31:0] res_req_q;
	logic [15:0] res_hdr_q;

	// slot memories
	logic          pmem [WINDOW];
	logic [63:0]   dmem [WINDOW];

	logic [31:0]   diff;
	logic [IW:0]   slot_sum;
	logic [IW:0]   slot_adj;
	logic [IW-1:0] slot_calc;
	logic [IW-1:0] rd_addr;
	logic [QW-1:0] off_ext;
	logic [QW-1:0] qlen_grow;
	logic          in_window;
	logic [IW-1:0] head_next;
	logic [31:0]   next_id;
	status_t       st_next;
	logic          do_store;
	logic          do_take;
	logic          pmem_we;
	logic [IW-1:0] pmem_wa;
	logic          pmem_wd;

	// offset past the last extracted ID
	assign diff = id_q - last_id_q - 32'd1;

	// head + offset modulo the window; both operands are below WINDOW
	assign slot_sum  = {1'b0, head_q} + {1'b0, offset_q};
	assign slot_adj  = (slot_sum >= WIN_W) ? (slot_sum - WIN_W) : slot_sum;
	assign slot_calc = slot_adj[IW-1:0];
	assign rd_addr   = (kind_q == KIND_EXTRACT) ? head_q : slot_calc;

	assign off_ext   = QW'(offset_q);
	assign qlen_grow = off_ext + QW'(1);
	assign in_window = off_ext < qlen_q;
	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + IW'(1);
	assign next_id   = last_id_q + 32'd1;

	always_comb begin
		st_next  = ST_NOT_READY;
		do_store = 1'b0;
		do_take  = 1'b0;
		unique case (kind_q)
			KIND_ENQUEUE: begin
				if (old_q)
					st_next = ST_OLD;
				else if (beyond_q)
					st_next = ST_BEYOND;
				else if (in_window && present_rd_q)
					st_next = ST_DUPLICATE;
				else begin
					st_next  = ST_STORED;
					do_store = 1'b1;
				end
			end
			KIND_EXTRACT: begin
				if (qlen_q == '0 || !present_rd_q)
					st_next = ST_NOT_READY;
				else begin
					st_next = ST_EXTRACTED;
					do_take = 1'b1;
				end
			end
			KIND_CLEAR: st_next = ST_CLEARED;
			default:    st_next = ST_NOT_READY;
		endcase
	end

	// single write port: sweep, store or take
	assign pmem_we = cmd.sweep || (cmd.exec && (do_store || do_take));
	assign pmem_wa = cmd.sweep ? sweep_cnt_q : slot_q;
	assign pmem_wd = !cmd.sweep && do_store;

	always_ff @(posedge clk) begin
		if (pmem_we)
			pmem[pmem_wa] <= pmem_wd;
		if (cmd.read)
			present_rd_q <= pmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_store)
			dmem[slot_q] <= {ref_q, req_q, hdr_q};
		if (cmd.read)
			data_rd_q <= dmem[rd_addr];
	end

	// payload and step registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			id_q   <= packet_id;
			ref_q  <= packet_ref;
			req_q  <= request_id;
			hdr_q  <= header_size;
		end
		if (cmd.calc) begin
			old_q    <= id_q <= last_id_q;
			beyond_q <= diff >= 32'(WINDOW);
			offset_q <= diff[IW-1:0];
		end
		if (cmd.read)
			slot_q <= rd_addr;
		if (cmd.exec) begin
			status_q  <= st_next;
			res_id_q  <= do_take ? next_id : '0;
			res_ref_q <= do_take ? data_rd_q[63:48] : '0;
			res_req_q <= do_take ? data_rd_q[47:16] : '0;
			res_hdr_q <= do_take ? data_rd_q[15:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_id_q   <= '0;
			qlen_q      <= '0;
			head_q      <= '0;
			sweep_cnt_q <= '0;
		end else begin
			if (cmd.sweep)
				sweep_cnt_q <= (sweep_cnt_q == LAST_SLOT) ? '0 : sweep_cnt_q + IW'(1);
			if (cmd.exec) begin
				if (do_store && !in_window)
					qlen_q <= qlen_grow;
				if (do_take) begin
					last_id_q <= next_id;
					head_q    <= head_next;
					qlen_q    <= qlen_q - QW'(1);
				end
				if (kind_q == KIND_CLEAR) begin
					last_id_q <= '0;
					qlen_q    <= '0;
					head_q    <= '0;
				end
			end
		end
	end

	assign sts.is_clear   = (kind_q == KIND_CLEAR);
	assign sts.sweep_done = (sweep_cnt_q == LAST_SLOT);

	assign status          = status_q;
	assign out_packet_id   = res_id_q;
	assign out_packet_ref  = res_ref_q;
	assign out_request_id  = res_req_q;
	assign out_header_size = res_hdr_q;

endmodule

[hw/rtl/packet_reorder_buffer.sv]
`timescale 1ns / 1ps
// Top level of the packet reorder buffer (sequence-number resequencer).
// Depends on prb_pkg, prb_ctrl and prb_datapath.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid / in_ready | kind, packet_id, packet_ref, request_id, header_size
//  out     | out_valid/out_ready | status, out_packet_id, out_packet_ref,
//          |                     | out_request_id, out_header_size
//
// Enqueue and extract go through accept, offset check, registered read of the
// slot memories, then execute with write-back into the same memories.
// A clear adds a sweep over the presence memory; after reset the same sweep
// runs with in_ready low.
// A result waits in the output register; the next beat is accepted meanwhile, and
// only its execute step holds while the previous result is still untaken.

module packet_reorder_buffer #(
	parameter int unsigned WINDOW = prb_pkg::WINDOW_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  prb_pkg::kind_t   kind,
	input  logic [31:0]      packet_id,
	input  logic [15:0]      packet_ref,
	input  logic [31:0]      request_id,
	input  logic [15:0]      header_size,
	output logic             out_valid,
	input  logic             out_ready,
	output prb_pkg::status_t status,
	output logic [31:0]      out_packet_id,
	output logic [15:0]      out_packet_ref,
	output logic [31:0]      out_request_id,
	output logic [15:0]      out_header_size
);
	import prb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	prb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prb_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.packet_id       (packet_id),
		.packet_ref      (packet_ref),
		.request_id      (request_id),
		.header_size     (header_size),
		.status          (status),
		.out_packet_id   (out_packet_id),
		.out_packet_ref  (out_packet_ref),
		.out_request_id  (out_request_id),
		.out_header_size (out_header_size)
	);

endmodule

[tb/prb_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the packet reorder buffer: tracks the resequencing window itself.
// Depends on prb_pkg; sits beside the block in packet_reorder_buffer_tb.

module prb_checker
	import prb_pkg::*;
#(
	parameter int unsigned WINDOW = prb_pkg::WINDOW_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  kind_t       kind,
	input  logic [31:0] packet_id,
	input  logic [15:0] packet_ref,
	input  logic [31:0] request_id,
	input  logic [15:0] header_size,
	input  logic        out_valid,
	input  logic        out_ready,
	input  status_t     status,
	input  logic [31:0] out_packet_id,
	input  logic [15:0] out_packet_ref,
	input  logic [31:0] out_request_id,
	input  logic [15:0] out_header_size,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned results_checked,
	output int unsigned delivered
);

	typedef struct packed {
		logic [15:0] handle;
		logic [31:0] req;
		logic [15:0] hdr;
	} parked_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] id;
		logic [15:0] handle;
		logic [31:0] req;
		logic [15:0] hdr;
	} outcome_t;

	// window state as the block should hold it
	bit          held [WINDOW];
	parked_t     stash [WINDOW];
	logic [31:0] last_id;
	int unsigned fill;
	int unsigned head;

	outcome_t owed [$];

	function automatic outcome_t resequence(input kind_t k, input logic [31:0] id,
			input logic [15:0] handle, input logic [31:0] req, input logic [15:0] hdr);
		outcome_t    r;
		logic [31:0] offset;
		int unsigned slot;
		r = '0;
		r.status = ST_NOT_READY;
		case (k)
			KIND_ENQUEUE: begin
				offset = id - last_id - 32'd1;
				if (id <= last_id) begin
					r.status = ST_OLD;
				end else if (offset >= WINDOW) begin
					r.status = ST_BEYOND;
				end else begin
					slot = (head + offset) % WINDOW;
					if (offset < fill && held[slot]) begin
						r.status = ST_DUPLICATE;
					end else begin
						// landing past the used part opens a gap of empty slots
						if (offset >= fill)
							fill = offset + 1;
						stash[slot] = '{handle, req, hdr};
						held[slot] = 1'b1;
						r.status = ST_STORED;
					end
				end
			end
			KIND_EXTRACT: begin
				if (fill != 0 && held[head]) begin
					r.status = ST_EXTRACTED;
					r.id = last_id + 32'd1;
					r.handle = stash[head].handle;
					r.req = stash[head].req;
					r.hdr = stash[head].hdr;
					held[head] = 1'b0;
					head = (head + 1) % WINDOW;
					fill--;
					last_id = last_id + 32'd1;
				end
			end
			KIND_CLEAR: begin
				foreach (held[s])
					held[s] = 1'b0;
				last_id = '0;
				fill = 0;
				head = 0;
				r.status = ST_CLEARED;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			foreach (held[s])
				held[s] = 1'b0;
			last_id = '0;
			fill = 0;
			head = 0;
			owed.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			delivered = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed.size() == 0) begin
					$error("status: expected no result beat, got %0d", status);
					fail_count++;
				end else begin
					want = owed[0];
					owed.delete(0);
					check_field("status", 32'(want.status), 32'(status));
					check_field("out_packet_id", want.id, out_packet_id);
					check_field("out_packet_ref", 32'(want.handle), 32'(out_packet_ref));
					check_field("out_request_id", want.req, out_request_id);
					check_field("out_header_size", 32'(want.hdr), 32'(out_header_size));
					results_checked++;
					if (want.status == ST_EXTRACTED)
						delivered++;
				end
			end
			if (in_valid && in_ready)
				owed.push_back(resequence(kind, packet_id, packet_ref, request_id,
					header_size));
			pending = owed.size();
		end
	end

endmodule

[tb/packet_reorder_buffer_tb.sv]
`timescale 1ns / 1ps
// Top of the packet reorder buffer testbench: clock, reset, stimulus and verdict.
// Depends on prb_pkg, packet_reorder_buffer and prb_checker.

module packet_reorder_buffer_tb;
	import prb_pkg::*;

	localparam int unsigned WINDOW         = prb_pkg::WINDOW_DEFAULT;
	localparam int unsigned RANDOM_BEATS   = 950;
	localparam int unsigned SQUEEZE_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES   = WINDOW + 40;
	localparam int unsigned CYCLE_LIMIT    = 400_000;
	localparam kind_t       KIND_UNUSED    = 2'd3;

	typedef enum int unsigned {RX_OPEN, RX_COIN, RX_MOSTLY, RX_EVERY4, RX_SPARSE} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	kind_t       kind;
	logic [31:0] packet_id;
	logic [15:0] packet_ref;
	logic [31:0] request_id;
	logic [15:0] header_size;
	logic        out_valid;
	logic        out_ready;
	status_t     status;
	logic [31:0] out_packet_id;
	logic [15:0] out_packet_ref;
	logic [31:0] out_request_id;
	logic [15:0] out_header_size;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_checked;
	int unsigned delivered;

	int unsigned cycle_count = 0;
	int unsigned beats_sent = 0;
	int unsigned enq_sent = 0;
	int unsigned ext_sent = 0;
	int unsigned clr_sent = 0;
	int unsigned burst_left = 0;
	logic        squeeze_req = 1'b0;
	logic [31:0] id_base;
	logic [31:0] batch_ids [$];

	packet_reorder_buffer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.packet_id      (packet_id),
		.packet_ref     (packet_ref),
		.request_id     (request_id),
		.header_size    (header_size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_packet_id  (out_packet_id),
		.out_packet_ref (out_packet_ref),
		.out_request_id (out_request_id),
		.out_header_size(out_header_size)
	);

	prb_checker #(.WINDOW(WINDOW)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.packet_id      (packet_id),
		.packet_ref     (packet_ref),
		.request_id     (request_id),
		.header_size    (header_size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_packet_id  (out_packet_id),
		.out_packet_ref (out_packet_ref),
		.out_request_id (out_request_id),
		.out_header_size(out_header_size),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_checked(results_checked),
		.delivered      (delivered)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// sender bursts: a random gap is taken only when a burst runs out
	task automatic send_beat(input kind_t k, input logic [31:0] id, input logic [15:0] handle,
			input logic [31:0] req, input logic [15:0] hdr);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(60, 160);
			end else begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(0, 12);
			end
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		packet_id <= id;
		packet_ref <= handle;
		request_id <= req;
		header_size <= hdr;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		case (k)
			KIND_ENQUEUE: enq_sent++;
			KIND_EXTRACT: ext_sent++;
			KIND_CLEAR:   clr_sent++;
			default: ;
		endcase
	endtask

	task automatic send_random(input kind_t k, input logic [31:0] id);
		send_beat(k, id, 16'($urandom_range(0, 16'hFFFF)), $urandom(),
			16'($urandom_range(0, 16'hFFFF)));
	endtask

	// receiver: shifting stall patterns, plus a long hold-off on request
	initial begin
		rx_mode_t    mode;
		int unsigned stretch;
		int unsigned phase;
		mode = RX_OPEN;
		stretch = 0;
		phase = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					mode = rx_mode_t'($urandom_range(0, 4));
					stretch = $urandom_range(20, 150);
				end
				stretch--;
				phase++;
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: out_ready <= ($urandom_range(0, 4) != 0);
					RX_EVERY4: out_ready <= (phase % 4 == 0);
					default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int unsigned n;
		int unsigned roll;
		int unsigned i;
		int unsigned j;
		int unsigned next_squeeze;
		logic [31:0] tmp;
		bit          broken;

		in_valid = 1'b0;
		kind = KIND_ENQUEUE;
		packet_id = '0;
		packet_ref = '0;
		request_id = '0;
		header_size = '0;
		next_squeeze = 350;
		@(posedge arst_n);
		@(posedge clk);

		// directed: empty window, odd kind, old, beyond, gap, duplicate, full window
		send_random(KIND_EXTRACT, 32'd0);
		send_random(KIND_UNUSED, 32'hFFFF_FFFF);
		send_random(KIND_ENQUEUE, 32'd0);
		send_random(KIND_ENQUEUE, WINDOW + 1);
		send_beat(KIND_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_beat(KIND_ENQUEUE, 32'd2, 16'h0000, 32'h0000_0000, 16'h0000);
		send_random(KIND_EXTRACT, 32'd0);
		send_random(KIND_ENQUEUE, 32'd2);
		send_beat(KIND_ENQUEUE, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_random(KIND_EXTRACT, 32'd0);
		send_random(KIND_EXTRACT, 32'd0);
		send_random(KIND_ENQUEUE, 32'd2);
		send_random(KIND_ENQUEUE, WINDOW + 2);
		send_random(KIND_ENQUEUE, WINDOW + 3);
		send_random(KIND_EXTRACT, 32'd0);
		send_random(KIND_CLEAR, 32'd0);
		send_random(KIND_EXTRACT, 32'd0);
		send_random(KIND_ENQUEUE, WINDOW + 2);
		send_random(KIND_ENQUEUE, WINDOW);
		send_random(KIND_ENQUEUE, 32'd1);
		send_random(KIND_EXTRACT, 32'd0);
		send_random(KIND_CLEAR, 32'd0);

		// random: shuffled runs of consecutive IDs with extracts and noise mixed in
		id_base = '0;
		while (beats_sent < 22 + RANDOM_BEATS) begin
			if (beats_sent >= next_squeeze) begin
				squeeze_req = 1'b1;
				next_squeeze += 400;
			end
			roll = $urandom_range(0, 9);
			if (roll < 6)
				n = $urandom_range(1, 10);
			else if (roll < 9)
				n = $urandom_range(11, 40);
			else
				n = ($urandom_range(0, 1) != 0) ? WINDOW : $urandom_range(41, WINDOW);
			batch_ids.delete();
			for (i = 1; i <= n; i++)
				batch_ids.push_back(id_base + i);
			for (i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = batch_ids[i];
				batch_ids[i] = batch_ids[j];
				batch_ids[j] = tmp;
			end
			// a lost packet leaves a hole that extracts cannot get past
			broken = (n > 1) && ($urandom_range(0, 9) == 0);
			if (broken)
				batch_ids.delete($urandom_range(0, n - 1));
			for (i = 0; i < batch_ids.size(); i++) begin
				if ($urandom_range(0, 3) == 0)
					send_random(KIND_EXTRACT, $urandom());
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 4))
						0: send_random(KIND_ENQUEUE, $urandom_range(0, id_base));
						1: send_random(KIND_ENQUEUE,
							(i == 0) ? 32'd0 : batch_ids[$urandom_range(0, i - 1)]);
						2: send_random(KIND_ENQUEUE,
							id_base + 2 * WINDOW + $urandom_range(0, 4000));
						3: send_random(KIND_ENQUEUE, 32'h8000_0000 | $urandom());
						default: send_random(KIND_UNUSED, $urandom());
					endcase
				end
				send_random(KIND_ENQUEUE, batch_ids[i]);
			end
			repeat (n) send_random(KIND_EXTRACT, $urandom());
			if (broken || $urandom_range(0, 11) == 0) begin
				send_random(KIND_CLEAR, $urandom());
				id_base = '0;
			end else begin
				id_base += n;
			end
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d beats: %0d enqueues, %0d extracts, %0d clears, rest unused kind.",
			beats_sent, enq_sent, ext_sent, clr_sent);
		$display("Checked %0d results; %0d packets came out in sequence.",
			results_checked, delivered);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
